// ----- rtl/core/lfu_cache_table_unit_macros.svh -----
// Assertion macros for the LFU cache table unit.
// Used by the port-level checker; no other dependencies.
`ifndef LFU_CACHE_TABLE_UNIT_MACROS_SVH
`define LFU_CACHE_TABLE_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LFU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication with the consequent checked in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/core/lfu_pkg.sv -----
// Package for the LFU cache table unit: widths, controller states and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none
package lfu_pkg;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CntW   = 16;
  localparam int unsigned StampW = 32;
  localparam int unsigned CapW   = 5;
  localparam logic [CntW-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_OUT
  } lfu_state_e;

  typedef struct packed {
    logic load;    // capture the input item, clear scan state
    logic scan;    // examine the slot at the scan index
    logic update;  // apply the access to the table
  } lfu_cmd_t;

  typedef struct packed {
    logic scan_last;  // scan index is at the final slot
  } lfu_stat_t;
endpackage
`default_nettype wire

// ----- rtl/core/lfu_if.sv -----
// Valid/ready channel interface for the LFU cache table unit.
// Payload type is a parameter; no package dependency.
`default_nettype none
interface lfu_if #(
  parameter type PayloadT = logic
);
  logic    valid;
  logic    ready;
  PayloadT payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lfu_ctrl.sv -----
// Controller state machine of the LFU cache table unit.
// Depends on lfu_pkg.
`default_nettype none
module lfu_ctrl
  import lfu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  lfu_stat_t stat_i,
  output lfu_cmd_t  cmd_o
);
  lfu_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/core/lfu_dp.sv -----
// Datapath of the LFU cache table unit: entry table, scan registers, update.
// Depends on lfu_pkg.
`default_nettype none
module lfu_dp
  import lfu_pkg::*;
#(
  parameter int unsigned MaxEntries = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  lfu_cmd_t               cmd_i,
  output lfu_stat_t              stat_o,
  input  wire logic [CapW-1:0]   cap_i,
  input  wire logic              action_i,
  input  wire logic [KeyW-1:0]   key_i,
  input  wire logic [ValW-1:0]   val_i,
  output logic                   hit_o,
  output logic [ValW-1:0]        read_value_o,
  output logic                   evicted_o,
  output logic [KeyW-1:0]        evicted_key_o
);
  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned OccW = $clog2(MaxEntries + 1);

  logic [MaxEntries-1:0] valid_q;
  logic [KeyW-1:0]       key_mem   [MaxEntries];
  logic [ValW-1:0]       val_mem   [MaxEntries];
  logic [CntW-1:0]       cnt_mem   [MaxEntries];
  logic [StampW-1:0]     stamp_mem [MaxEntries];
  logic [StampW-1:0]     clock_q;
  logic [OccW-1:0]       occ_q;

  logic            put_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic [IdxW-1:0] idx_q;
  logic            found_q, free_ok_q, vic_ok_q;
  logic [IdxW-1:0] found_idx_q, free_idx_q, vic_idx_q;
  logic [CntW-1:0] vic_cnt_q;
  logic [StampW-1:0] vic_stamp_q;

  logic [OccW-1:0] cap_eff;
  logic            better;
  logic            cap_le;

  assign cap_le  = ({{(32-CapW){1'b0}}, cap_i} <= 32'(MaxEntries));
  assign cap_eff = cap_le ? OccW'(cap_i) : OccW'(MaxEntries);
  assign stat_o.scan_last = (idx_q == IdxW'(MaxEntries - 1));
  assign better = !vic_ok_q || (cnt_mem[idx_q] < vic_cnt_q) ||
                  ((cnt_mem[idx_q] == vic_cnt_q) && (stamp_mem[idx_q] < vic_stamp_q));

  // Scan registers: one slot per cycle for key match, free slot and victim.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      found_q   <= 1'b0;
      free_ok_q <= 1'b0;
      vic_ok_q  <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q     <= '0;
      found_q   <= 1'b0;
      free_ok_q <= 1'b0;
      vic_ok_q  <= 1'b0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + 1'b1;
      if (valid_q[idx_q]) begin
        if (!found_q && key_mem[idx_q] == key_q) begin
          found_q <= 1'b1;
        end
        if (better) begin
          vic_ok_q <= 1'b1;
        end
      end else if (!free_ok_q) begin
        free_ok_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      put_q <= action_i;
      key_q <= key_i;
      val_q <= val_i;
    end else if (cmd_i.scan) begin
      if (valid_q[idx_q]) begin
        if (!found_q && key_mem[idx_q] == key_q) begin
          found_idx_q <= idx_q;
        end
        if (better) begin
          vic_idx_q   <= idx_q;
          vic_cnt_q   <= cnt_mem[idx_q];
          vic_stamp_q <= stamp_mem[idx_q];
        end
      end else if (!free_ok_q) begin
        free_idx_q <= idx_q;
      end
    end
  end

  // Update step: decide the destination slot, write the table and register the result.
  logic            do_touch, do_insert, do_evict;
  logic [IdxW-1:0] dst;
  always_comb begin
    do_touch  = found_q && (!put_q || cap_eff != '0);
    do_evict  = put_q && !found_q && cap_eff != '0 && occ_q >= cap_eff && vic_ok_q;
    do_insert = put_q && !found_q && cap_eff != '0 &&
                ((occ_q >= cap_eff) ? vic_ok_q : free_ok_q);
    dst       = do_evict ? vic_idx_q : free_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      clock_q <= '0;
      occ_q   <= '0;
    end else if (cmd_i.update) begin
      if (do_touch || do_insert) begin
        clock_q <= clock_q + 1'b1;
      end
      if (do_insert) begin
        valid_q[dst] <= 1'b1;
        if (!do_evict) begin
          occ_q <= occ_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_o         <= found_q;
      read_value_o  <= (found_q && !put_q) ? val_mem[found_idx_q] : '0;
      evicted_o     <= do_evict;
      evicted_key_o <= do_evict ? key_mem[vic_idx_q] : '0;
      if (do_touch) begin
        if (cnt_mem[found_idx_q] != CountMax) begin
          cnt_mem[found_idx_q] <= cnt_mem[found_idx_q] + 1'b1;
        end
        stamp_mem[found_idx_q] <= clock_q;
        if (put_q) begin
          val_mem[found_idx_q] <= val_q;
        end
      end else if (do_insert) begin
        key_mem[dst]   <= key_q;
        val_mem[dst]   <= val_q;
        cnt_mem[dst]   <= CntW'(1);
        stamp_mem[dst] <= clock_q;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/lfu_cache_table_unit.sv -----
// LFU cache table unit: one item in, one result out. Each item is loaded,
// checked against every slot by the per-slot scan, one slot a cycle, then
// applied to the table and offered as a result; a new item is taken
// only after the previous result has left.
// Reset (async, active low) empties the table, zeroes the access clock and
// occupancy, and sets the capacity to 16.
`default_nettype none
module lfu_cache_table_unit
  import lfu_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  lfu_if.sink                  in_if,
  lfu_if.source                out_if,
  input  wire logic            cfg_we_i,
  input  wire logic [CapW-1:0] cfg_wdata_i
);
  // The user must write the capacity register only while the unit is idle; the block never checks.
  logic [CapW-1:0] cap_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapW'(16);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  lfu_cmd_t  cmd;
  lfu_stat_t stat;

  // Controller sequences load, scan over every slot, update and output.
  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the table and the result registers, which stay put
  // while the result waits to be taken.
  lfu_dp #(.MaxEntries(MAX_ENTRIES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cap_i         (cap_q),
    .action_i      (in_if.payload.action),
    .key_i         (in_if.payload.lookup_key),
    .val_i         (in_if.payload.store_value),
    .hit_o         (out_if.payload.hit),
    .read_value_o  (out_if.payload.read_value),
    .evicted_o     (out_if.payload.evicted),
    .evicted_key_o (out_if.payload.evicted_key)
  );
endmodule
`default_nettype wire

// ----- rtl/core/lfu_checker.sv -----
// Port-level checker for the LFU cache table unit, bound to the top level.
// Depends on the assertion macros header.
`default_nettype none
`include "lfu_cache_table_unit_macros.svh"
module lfu_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic evicted_i,
  input wire logic [31:0] evicted_key_i,
  input wire logic [31:0] read_value_i,
  input wire logic hit_i
);
  `LFU_ASSERT_IMPL(a_one_side, clk_i, rst_ni, out_valid_i, !in_ready_i, "accepting while result pending")
  `LFU_ASSERT_NEXT(a_no_quick_out, clk_i, rst_ni, in_valid_i && in_ready_i, !out_valid_i, "result too early")
  `LFU_ASSERT_IMPL(a_evk_zero, clk_i, rst_ni, out_valid_i && !evicted_i, evicted_key_i == 32'd0, "evicted key not zero")
  `LFU_ASSERT_IMPL(a_hit_evict, clk_i, rst_ni, out_valid_i && hit_i, !evicted_i, "hit with eviction")
  `LFU_ASSERT_IMPL(a_rd_zero, clk_i, rst_ni, out_valid_i && !hit_i, read_value_i == 32'd0, "miss with data")
endmodule

bind lfu_cache_table_unit lfu_checker u_lfu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .evicted_i     (out_if.payload.evicted),
  .evicted_key_i (out_if.payload.evicted_key),
  .read_value_i  (out_if.payload.read_value),
  .hit_i         (out_if.payload.hit)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the LFU cache table unit (lfu_cache_table_unit).
// Depends on lfu_pkg and the lfu_if channel interface; predicts every result itself.
`default_nettype none
module tb_top;
  import lfu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = 16;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned KeyPool = 24;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_e;

  // Fields of one input item: action, key, value.
  typedef struct packed {
    logic          action;
    logic [KeyW-1:0] lookup_key;
    logic [ValW-1:0] store_value;
  } access_t;

  typedef struct packed {
    logic            hit;
    logic [ValW-1:0] read_value;
    logic            evicted;
    logic [KeyW-1:0] evicted_key;
  } outcome_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CapW-1:0] cfg_wdata_i;

  lfu_if #(.PayloadT(access_t))  req_ch ();
  lfu_if #(.PayloadT(outcome_t)) rsp_ch ();

  lfu_cache_table_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (req_ch),
    .out_if     (rsp_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Shadow copy of the cache table, kept in step with every accepted item.
  logic              sh_valid [Slots];
  logic [KeyW-1:0]   sh_key   [Slots];
  logic [ValW-1:0]   sh_value [Slots];
  logic [CntW-1:0]   sh_count [Slots];
  logic [StampW-1:0] sh_stamp [Slots];
  logic [StampW-1:0] sh_clock;
  int unsigned       sh_occupancy;
  int unsigned       sh_capacity;

  access_t  pending_items [$];
  outcome_t expected_outcomes [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_sender;
  logic [KeyW-1:0] key_pool [KeyPool];

  // Bump an entry: count saturates, recency is always renewed.
  function automatic void bump_entry(int slot);
    if (sh_count[slot] != CountMax) sh_count[slot] = sh_count[slot] + 1'b1;
    sh_stamp[slot] = sh_clock;
    sh_clock = sh_clock + 1'b1;
  endfunction

  function automatic outcome_t predict_access(access_t acc);
    outcome_t res;
    int found;
    int dst;
    int unsigned cap;
    res = '0;
    found = -1;
    dst = -1;
    cap = (sh_capacity > Slots) ? Slots : sh_capacity;
    for (int i = 0; i < Slots; i++) begin
      if (found < 0 && sh_valid[i] && sh_key[i] == acc.lookup_key) found = i;
    end
    res.hit = (found >= 0);
    if (acc.action == ACT_GET) begin
      if (found >= 0) begin
        res.read_value = sh_value[found];
        bump_entry(found);
      end
    end else if (cap != 0) begin
      if (found >= 0) begin
        sh_value[found] = acc.store_value;
        bump_entry(found);
      end else begin
        if (sh_occupancy >= cap) begin
          // Victim: lowest count, then oldest stamp, then lowest slot.
          for (int i = 0; i < Slots; i++) begin
            if (sh_valid[i] && (dst < 0 || sh_count[i] < sh_count[dst] ||
                (sh_count[i] == sh_count[dst] && sh_stamp[i] < sh_stamp[dst]))) begin
              dst = i;
            end
          end
          if (dst >= 0) begin
            res.evicted = 1'b1;
            res.evicted_key = sh_key[dst];
          end
        end else begin
          for (int i = 0; i < Slots; i++) begin
            if (dst < 0 && !sh_valid[i]) dst = i;
          end
          if (dst >= 0) sh_occupancy++;
        end
        if (dst >= 0) begin
          sh_valid[dst] = 1'b1;
          sh_key[dst]   = acc.lookup_key;
          sh_value[dst] = acc.store_value;
          sh_count[dst] = 1;
          sh_stamp[dst] = sh_clock;
          sh_clock = sh_clock + 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Sender: presents the next pending item, idling at random between items.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_items.size() > 0 && !hold_sender &&
          $urandom_range(99) >= send_idle_pct) begin
        req_ch.payload <= pending_items.pop_front();
        req_ch.valid   <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Every accepted item yields exactly one expected outcome.
  always @(posedge clk_i) begin
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      expected_outcomes.push_back(predict_access(req_ch.payload));
    end
  end

  // Receiver: random back-pressure, and the field-by-field check.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, rsp_ch.payload);
          mismatches++;
        end else begin
          outcome_t exp_res;
          exp_res = expected_outcomes.pop_front();
          if (rsp_ch.payload.hit !== exp_res.hit) begin
            $display("%0t: hit expected %0b actual %0b", $realtime,
                     exp_res.hit, rsp_ch.payload.hit);
            mismatches++;
          end
          if (rsp_ch.payload.read_value !== exp_res.read_value) begin
            $display("%0t: read_value expected %h actual %h", $realtime,
                     exp_res.read_value, rsp_ch.payload.read_value);
            mismatches++;
          end
          if (rsp_ch.payload.evicted !== exp_res.evicted) begin
            $display("%0t: evicted expected %0b actual %0b", $realtime,
                     exp_res.evicted, rsp_ch.payload.evicted);
            mismatches++;
          end
          if (rsp_ch.payload.evicted_key !== exp_res.evicted_key) begin
            $display("%0t: evicted_key expected %h actual %h", $realtime,
                     exp_res.evicted_key, rsp_ch.payload.evicted_key);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_item(action_e act, logic [KeyW-1:0] key, logic [ValW-1:0] val);
    access_t acc;
    acc.action = act;
    acc.lookup_key = key;
    acc.store_value = val;
    pending_items.push_back(acc);
  endtask

  // Block until every queued item has gone and every outcome has come back.
  task automatic wait_drained();
    while (pending_items.size() != 0 || req_ch.valid || expected_outcomes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(int unsigned cap);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap[CapW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sh_capacity = cap;
  endtask

  // Mostly keys from a small pool so hits and evictions are frequent.
  task automatic queue_random(int unsigned count);
    logic [KeyW-1:0] key;
    for (int n = 0; n < count; n++) begin
      key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(KeyPool - 1)] : $urandom;
      queue_item(($urandom_range(1) != 0) ? ACT_PUT : ACT_GET, key, $urandom);
    end
  endtask

  initial begin
    int unsigned caps [8];
    caps = '{0, 1, 31, 4, 2, 17, 8, 16};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    hold_sender = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    send_idle_pct = 37;
    recv_idle_pct = 51;
    for (int i = 0; i < Slots; i++) begin
      sh_valid[i] = 1'b0;
      sh_key[i] = '0;
      sh_value[i] = '0;
      sh_count[i] = '0;
      sh_stamp[i] = '0;
    end
    sh_clock = '0;
    sh_occupancy = 0;
    sh_capacity = 16;
    for (int i = 0; i < KeyPool; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: miss on empty table, extreme keys and values, hits, overwrite,
    // then filling all sixteen slots so a new key evicts by count and recency.
    queue_item(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_item(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_item(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_item(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_item(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_item(ACT_GET, 32'h8000_0000, 32'h0);
    queue_item(ACT_GET, 32'h7FFF_FFFF, 32'h0);
    queue_item(ACT_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
    queue_item(ACT_GET, 32'hFFFF_FFFF, 32'h0);
    for (int i = 0; i < 12; i++) queue_item(ACT_PUT, 32'h100 + i, 32'h5A00 + i);
    // Table full: slot holding key 0 has the lowest count and oldest stamp
    // among the count-one entries, so it goes first, then key 0x100.
    queue_item(ACT_PUT, 32'h200, 32'h1);
    queue_item(ACT_PUT, 32'h201, 32'h2);
    queue_item(ACT_GET, 32'h0000_0000, 32'h0);
    queue_item(ACT_GET, 32'h200, 32'h0);
    wait_drained();

    // Capacity zero first: puts are dropped but gets still hit.
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 37;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_capacity(caps[p]);
      if (caps[p] == 0) queue_item(ACT_GET, 32'h200, 32'h0);
      queue_random(67);
      if (p == 2) begin
        // Hold the sender until the block has returned every outcome.
        hold_sender = 1'b1;
        while (expected_outcomes.size() != 0 || req_ch.valid) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      queue_random(67);
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lfu_pkg.sv
rtl/core/lfu_if.sv
rtl/core/lfu_ctrl.sv
rtl/core/lfu_dp.sv
rtl/core/lfu_cache_table_unit.sv
rtl/core/lfu_checker.sv
verif/tb_top.sv
